>>> design/c2mf_pkg.sv
package c2mf_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned SumW    = 40;
  localparam int unsigned PosW    = 6;
  localparam int unsigned FiltW   = 2;
  localparam int unsigned WIdxW   = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 7;

  localparam logic CmdWeight = 1'b0;
  localparam logic CmdPixel  = 1'b1;

  localparam logic [CfgIdxW-1:0] RegImageRows   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageCols   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKernelSize  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFilterCount = 2'd3;

  typedef struct packed {
    logic                    cmd;
    logic [WIdxW-1:0]        weight_index;
    logic signed [DataW-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]        window_row;
    logic [PosW-1:0]        window_col;
    logic [FiltW-1:0]       filter_number;
    logic signed [SumW-1:0] dot_sum;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic                   [CfgIdxW-1:0] index;
    logic                   [CfgDatW-1:0] data;
  } cfg_item_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

>>> design/c2mf_if.sv
interface c2mf_in_if;
  import c2mf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2mf_out_if;
  import c2mf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2mf_cfg_if;
  import c2mf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/c2mf_mac_cell.sv
module c2mf_mac_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  c2mf_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [c2mf_pkg::DataW-1:0]      pixel_i,
  input  logic signed [c2mf_pkg::DataW-1:0]      weight_i,
  output logic signed [c2mf_pkg::SumW-1:0]       acc_o
);
  import c2mf_pkg::*;

  logic signed [2*DataW-1:0] prod_q, prod_d;
  logic                      pv_q, pclr_q;
  logic signed [SumW-1:0]    acc_q, acc_d;

  assign prod_d = pixel_i * weight_i;

  always_comb begin
    acc_d = acc_q;
    if (pclr_q) acc_d = '0;
    if (pv_q) acc_d = acc_d + SumW'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      pclr_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      pv_q   <= ctrl_i.valid;
      pclr_q <= ctrl_i.clear;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o = acc_q;
endmodule

>>> design/conv2d_multi_filter_core.sv
// conv2d_multi_filter_core: valid stride-one 2-d convolution with several filters
// in_if carries items: cmd 0 writes one weight, cmd 1 is one pixel in raster order
// cfg_if writes image_rows, image_cols, kernel_size, filter_count while idle
// out_if gives one sum per filter, in filter order, last set on the final filter
// a row of MAX_FILTERS mac cells, one per filter, walks the window taps:
// one tap per cycle, pixel and every cell's weight read from the stores
// a weight item or a pixel that closes no window leaves the core idle
// a pixel that closes a window starts the tap walk through the single-port
// stores, then the read, product and accumulate stages flush, then the sums
// drain through the output register, one per filter
// reset clears position and sets configuration (4, 4, 2, 2); stores hold no reset
// value and must be written before they are read
// a stalled receiver holds the current sum; no new item is taken meanwhile
module conv2d_multi_filter_core #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned MAX_KERNEL  = 4,
  parameter int unsigned MAX_FILTERS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2mf_in_if.sink   in_if,
  c2mf_cfg_if.sink  cfg_if,
  c2mf_out_if.source out_if
);
  import c2mf_pkg::*;

  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1);
  localparam int unsigned FW     = $clog2(MAX_FILTERS + 1);
  localparam int unsigned KRW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned RW     = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW    = $clog2(MAX_COLS + 1);
  localparam int unsigned LDEP   = MAX_KERNEL * MAX_COLS;
  localparam int unsigned LAW    = $clog2(LDEP);
  localparam int unsigned WDEP   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned TW     = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int unsigned FIW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned PW     = (RW > CCW) ? RW : CCW;
  // weight store split into banks by the low address bits, so that the
  // filter_count consecutive weights of one tap sit in distinct banks
  localparam int unsigned WTOT   = WDEP * MAX_FILTERS;
  localparam int unsigned NBW    = (MAX_FILTERS > 2) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned NB     = 1 << NBW;
  localparam int unsigned BDEP   = (WTOT + NB - 1) / NB;
  localparam int unsigned BAW    = (BDEP > 1) ? $clog2(BDEP) : 1;
  localparam int unsigned WAW    = NBW + BAW;

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_FLUSH, S_EMIT} state_e;

  state_e state_q;
  logic [CfgDatW-1:0] rows_q, cols_q;
  logic [2:0]         ksz_q, nfc_q;
  logic [PW-1:0]      prow_q, pcol_q;

  // clamped configuration
  logic [RW-1:0]  rows;
  logic [CCW-1:0] cols;
  logic [KW-1:0]  kk;
  logic [FW-1:0]  nf;

  always_comb begin
    rows = (rows_q == '0) ? RW'(1) :
           ((32'(rows_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_q));
    cols = (cols_q == '0) ? CCW'(1) :
           ((32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q));
    kk   = (ksz_q == '0) ? KW'(1) :
           ((32'(ksz_q) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ksz_q));
    nf   = (nfc_q == '0) ? FW'(1) :
           ((32'(nfc_q) > MAX_FILTERS) ? FW'(MAX_FILTERS) : FW'(nfc_q));
  end

  // stores
  logic signed [DataW-1:0] line_mem [LDEP];
  logic signed [DataW-1:0] wgt_mem [NB][BDEP];

  assign cfg_if.ready = (state_q == S_IDLE);
  assign in_if.ready  = (state_q == S_IDLE);

  logic in_acc;
  assign in_acc = in_if.valid && in_if.ready;

  logic in_img, win_done;
  assign in_img   = (32'(prow_q) < 32'(rows)) && (32'(pcol_q) < 32'(cols));
  assign win_done = in_img && (32'(kk) <= 32'(rows)) && (32'(kk) <= 32'(cols))
                 && (32'(prow_q) + 1 >= 32'(kk)) && (32'(pcol_q) + 1 >= 32'(kk));

  // flat weight address
  logic [WAW-1:0] w_addr;
  logic           w_ok;
  assign w_addr = WAW'(in_if.data.weight_index);
  assign w_ok   = (32'(in_if.data.weight_index) < WTOT);

  logic [KRW-1:0] lrow_wr;
  assign lrow_wr = KRW'(32'(prow_q) % MAX_KERNEL);

  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.data.cmd == CmdWeight && w_ok) begin
      wgt_mem[w_addr[NBW-1:0]][w_addr[WAW-1:NBW]] <= in_if.data.data_value;
    end
    if (in_acc && in_if.data.cmd == CmdPixel && in_img) begin
      line_mem[LAW'(32'(lrow_wr) * MAX_COLS + 32'(pcol_q))] <= in_if.data.data_value;
    end
  end

  // window walk
  logic [PW-1:0] top_q, left_q;
  logic [KW-1:0] fi_q, fj_q;
  logic [TW-1:0] tap_q;
  logic          walk_v;
  logic [LAW-1:0] rd_addr;
  logic signed [DataW-1:0] pix_q;
  logic signed [DataW-1:0] wbank_q [NB];
  logic [NBW-1:0] wsel_q;
  logic [WAW-1:0] w_base;
  logic [NBW-1:0] bank_off [NB];
  logic [WAW-1:0] bank_rd [NB];
  logic          rd_v_q, rd_clr_q, first_q;
  logic [1:0]    flush_q;
  logic [FIW-1:0] emit_q;
  logic [FIW:0]   last_f;

  assign walk_v  = (state_q == S_WALK);
  assign rd_addr = LAW'(((32'(top_q) + 32'(fi_q)) % MAX_KERNEL) * MAX_COLS
                        + 32'(left_q) + 32'(fj_q));
  assign last_f  = (FIW+1)'(nf) - 1'b1;

  // weight of filter f for this tap lives at tap * filter_count + f
  assign w_base = WAW'(32'(tap_q) * 32'(nf));

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      bank_off[b] = NBW'(b) - w_base[NBW-1:0];
      bank_rd[b]  = w_base + WAW'(bank_off[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= line_mem[rd_addr];
    wsel_q <= w_base[NBW-1:0];
    for (int b = 0; b < NB; b++) wbank_q[b] <= wgt_mem[b][bank_rd[b][WAW-1:NBW]];
  end

  mac_ctrl_t ctrl;
  assign ctrl.valid = rd_v_q;
  assign ctrl.clear = rd_clr_q;

  logic signed [SumW-1:0] acc [MAX_FILTERS];

  for (genvar g = 0; g < MAX_FILTERS; g++) begin : g_cell
    c2mf_mac_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .pixel_i(pix_q),
      .weight_i(wbank_q[NBW'(wsel_q + NBW'(g))]), .acc_o(acc[g])
    );
  end

  // sums shift toward cell zero while emitting
  logic signed [SumW-1:0] sum_q [MAX_FILTERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rows_q   <= 7'd4;
      cols_q   <= 7'd4;
      ksz_q    <= 3'd2;
      nfc_q    <= 3'd2;
      prow_q   <= '0;
      pcol_q   <= '0;
      top_q    <= '0;
      left_q   <= '0;
      fi_q     <= '0;
      fj_q     <= '0;
      tap_q    <= '0;
      rd_v_q   <= 1'b0;
      rd_clr_q <= 1'b0;
      first_q  <= 1'b0;
      flush_q  <= '0;
      emit_q   <= '0;
    end else begin
      rd_v_q   <= walk_v;
      rd_clr_q <= walk_v && first_q;
      if (walk_v) first_q <= 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_if.data.index)
          RegImageRows:   rows_q <= cfg_if.data.data;
          RegImageCols:   cols_q <= cfg_if.data.data;
          RegKernelSize:  ksz_q  <= cfg_if.data.data[2:0];
          RegFilterCount: nfc_q  <= cfg_if.data.data[2:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_if.data.cmd == CmdPixel) begin
            if (win_done) begin
              top_q   <= PW'(32'(prow_q) + 1 - 32'(kk));
              left_q  <= PW'(32'(pcol_q) + 1 - 32'(kk));
              fi_q    <= '0;
              fj_q    <= '0;
              tap_q   <= '0;
              first_q <= 1'b1;
              state_q <= S_WALK;
            end
            if (32'(pcol_q) + 1 >= 32'(cols)) begin
              pcol_q <= '0;
              prow_q <= (32'(prow_q) + 1 >= 32'(rows)) ? '0 : PW'(32'(prow_q) + 1);
            end else begin
              pcol_q <= pcol_q + 1'b1;
            end
          end
        end
        S_WALK: begin
          tap_q <= tap_q + 1'b1;
          if (fj_q + 1'b1 == kk) begin
            fj_q <= '0;
            fi_q <= fi_q + 1'b1;
            if (fi_q + 1'b1 == kk) begin
              flush_q <= '0;
              state_q <= S_FLUSH;
            end
          end else begin
            fj_q <= fj_q + 1'b1;
          end
        end
        S_FLUSH: begin
          // read, product and accumulate stages drain
          flush_q <= flush_q + 1'b1;
          if (flush_q == 2'd2) begin
            emit_q  <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_if.ready) begin
            emit_q <= emit_q + 1'b1;
            if ({1'b0, emit_q} == last_f) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < MAX_FILTERS; f++) begin
      if (state_q == S_FLUSH && flush_q == 2'd2) begin
        sum_q[f] <= acc[f];
      end else if (state_q == S_EMIT && out_if.ready) begin
        sum_q[f] <= (f + 1 < MAX_FILTERS) ? sum_q[(f + 1) % MAX_FILTERS] : sum_q[f];
      end
    end
  end

  assign out_if.valid              = (state_q == S_EMIT);
  assign out_if.data.window_row    = PosW'(top_q);
  assign out_if.data.window_col    = PosW'(left_q);
  assign out_if.data.filter_number = FiltW'(emit_q);
  assign out_if.data.dot_sum       = sum_q[0];
  assign out_if.data.last          = ({1'b0, emit_q} == last_f);

endmodule

>>> design/c2mf_checker.sv
module c2mf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                cfg_ready,
  input c2mf_pkg::out_item_t out_data
);
  import c2mf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item dropped while stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready && !cfg_ready)
    else $error("input taken while results pending");

  a_filter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.filter_number == $past(out_data.filter_number) + 2'd1)
    else $error("filter order broken");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_data.last |=> !out_valid && in_ready)
    else $error("no return to idle after last");
endmodule

bind conv2d_multi_filter_core c2mf_checker u_c2mf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .cfg_ready (cfg_if.ready),
  .out_data  (out_if.data)
);
